>>> hdl/bfdh_pkg.sv
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared types and constants for the double-hash Bloom filter block.
// ----------------------------------------------------------------------------
package bfdh_pkg;

   // Store geometry
   localparam int WORD_W    = 64;
   localparam int BIT_IDX_W = 6;

   // Defaults for the top level parameters
   localparam int FILTER_BITS_DEF = 65536;
   localparam int MAX_PROBES_DEF  = 16;

   // Register file
   localparam int                   CSR_ADDR_W     = 3;
   localparam int                   CSR_DATA_W     = 32;
   localparam int                   NUM_PROBES_W   = 5;
   localparam logic [NUM_PROBES_W-1:0] NUM_PROBES_RST = 5'd2;
   // register index, taken from paddr[2]
   localparam logic                 REG_NUM_PROBES = 1'b0;

   // Request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // capture hashes of a new request
      logic rd;       // read the word of the current probe
      logic set_wr;   // write back the read word with the probe bit set
      logic clr_wr;   // write zero at the clear pointer
      logic advance;  // step to the next probe position
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clr_last; // clear pointer is on the last word
      logic bit_hit;  // probe bit in the read word is set
   } dp_sts_type;

endpackage

>>> hdl/bfdh_csr.sv
// ----------------------------------------------------------------------------
// bfdh_csr
// APB-style register port holding the probe count.
// ----------------------------------------------------------------------------
module bfdh_csr
   import bfdh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready,
   output logic [NUM_PROBES_W-1:0] num_probes
);

   logic [NUM_PROBES_W-1:0] num_probes_ff;
   logic [NUM_PROBES_W-1:0] num_probes_in;
   logic                    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   // Register write decode
   always_comb begin
      num_probes_in = num_probes_ff;
      if (wr_en && (paddr[2] == REG_NUM_PROBES)) begin
         num_probes_in = pwdata[NUM_PROBES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_probes_ff <= NUM_PROBES_RST;
      end else begin
         num_probes_ff <= num_probes_in;
      end
   end

   // Read back
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_NUM_PROBES) begin
         prdata = CSR_DATA_W'(num_probes_ff);
      end
   end

   assign num_probes = num_probes_ff;

endmodule

>>> hdl/bfdh_dpath.sv
// ----------------------------------------------------------------------------
// bfdh_dpath
// Probe position stepping, filter word memory and bit test / set.
// ----------------------------------------------------------------------------
module bfdh_dpath
   import bfdh_pkg::*;
#(
   parameter int FILTER_BITS = FILTER_BITS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [63:0]       req_hash_a,
   input  logic [63:0]       req_hash_b,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts
);

   localparam int POS_W   = $clog2(FILTER_BITS);
   localparam int WORDS   = FILTER_BITS / WORD_W;
   localparam int WADDR_W = (POS_W > BIT_IDX_W) ? POS_W - BIT_IDX_W : 1;

   logic [POS_W-1:0]     pos_ff;
   logic [POS_W-1:0]     pos_in;
   logic [POS_W-1:0]     stride_ff;
   logic [POS_W-1:0]     stride_in;
   logic [WADDR_W-1:0]   clr_addr_ff;
   logic [WADDR_W-1:0]   clr_addr_in;
   logic [WORD_W-1:0]    rd_data_ff;
   logic [WADDR_W-1:0]   word_addr;
   logic [WADDR_W-1:0]   mem_addr;
   logic [BIT_IDX_W-1:0] bit_sel;
   logic [WORD_W-1:0]    set_mask;
   logic [WORD_W-1:0]    mem [WORDS];

   // Position only needs the low bits since the size is a power of two
   always_comb begin
      pos_in    = pos_ff;
      stride_in = stride_ff;
      if (cmd.load) begin
         pos_in    = req_hash_a[POS_W-1:0];
         stride_in = req_hash_b[POS_W-1:0];
      end else if (cmd.advance) begin
         pos_in = pos_ff + stride_ff;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      stride_ff <= stride_in;
   end

   // Clear pointer for the sweep after reset
   assign clr_addr_in = cmd.clr_wr ? clr_addr_ff + 1'b1 : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign sts.clr_last = (clr_addr_ff == WADDR_W'(WORDS - 1));

   // Word address and bit in word, bit 0 of a position is the word's MSB
   assign word_addr = WADDR_W'(pos_ff >> BIT_IDX_W);
   assign bit_sel   = ~pos_ff[BIT_IDX_W-1:0];
   assign set_mask  = {{(WORD_W-1){1'b0}}, 1'b1} << bit_sel;
   assign mem_addr  = cmd.clr_wr ? clr_addr_ff : word_addr;

   // Single port filter store
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[mem_addr] <= '0;
      end else if (cmd.set_wr) begin
         mem[mem_addr] <= rd_data_ff | set_mask;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   assign sts.bit_hit = rd_data_ff[bit_sel];

endmodule

>>> hdl/bfdh_ctrl.sv
// ----------------------------------------------------------------------------
// bfdh_ctrl
// Sequencer: clear sweep, per-probe read / check, result register.
// ----------------------------------------------------------------------------
module bfdh_ctrl
   import bfdh_pkg::*;
#(
   parameter int MAX_PROBES = MAX_PROBES_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_kind,
   output logic                    req_stall,
   input  logic [NUM_PROBES_W-1:0] num_probes,
   output dp_cmd_type              cmd,
   input  dp_sts_type              sts,
   output logic                    rsp_valid,
   output logic                    rsp_maybe_present,
   input  logic                    rsp_stall
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   logic                    kind_ff;
   logic                    kind_in;
   logic [NUM_PROBES_W-1:0] cnt_ff;
   logic [NUM_PROBES_W-1:0] cnt_in;
   logic [NUM_PROBES_W-1:0] k_ff;
   logic [NUM_PROBES_W-1:0] k_in;
   logic                    hit_ff;
   logic                    hit_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_mp_ff;
   logic                    rsp_mp_in;
   logic [NUM_PROBES_W-1:0] k_eff;
   logic                    req_acc;
   logic                    last_probe;
   logic                    out_free;

   // Probe count limited to MAX_PROBES
   always_comb begin
      k_eff = num_probes;
      if (32'(num_probes) > MAX_PROBES) begin
         k_eff = NUM_PROBES_W'(MAX_PROBES);
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_acc    = req_valid & ~req_stall;
   assign last_probe = (cnt_ff == k_ff - 1'b1);
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_mp_in    = rsp_mp_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               cmd.load = 1'b1;
               kind_in  = req_kind;
               cnt_in   = '0;
               k_in     = k_eff;
               hit_in   = 1'b1;
               if (k_eff != '0) begin
                  state_in = ST_READ;
               end else if (req_kind == KIND_QUERY) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (kind_ff == KIND_INSERT) begin
               cmd.set_wr = 1'b1;
            end
            if ((kind_ff == KIND_QUERY) && !sts.bit_hit) begin
               // miss ends the query early
               hit_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               cmd.advance = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
               if (!last_probe) begin
                  state_in = ST_READ;
               end else if (kind_ff == KIND_QUERY) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mp_in    = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      hit_ff    <= hit_in;
      rsp_mp_ff <= rsp_mp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = rsp_mp_ff;

   // Probe counter stays below the probe count while probing
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_CHECK) |-> (cnt_ff < k_ff))
      else $error("probe counter out of range");

   // Only inserts write the store outside the clear sweep
   a_set_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.set_wr |-> (kind_ff == KIND_INSERT))
      else $error("store write during a query");

   // A new response only comes out of the done state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");

   // No response while the store is being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clear sweep");

endmodule

>>> hdl/bloom_filter_double_hash_top.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_top
// Bloom filter bit store probed by two precomputed 64-bit hashes per key.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries req_kind (0 insert, 1 query) and two hashes. Probe i
//   addresses bit (hash_a + i*hash_b) mod FILTER_BITS, bits numbered MSB
//   first within each 64-bit word. An insert sets every probed bit and gives
//   no response; a query gives one response, rsp_maybe_present, set when all
//   probed bits are set. The probe count k sits in register 0 (reset 2),
//   limited to MAX_PROBES; k = 0 makes inserts no-ops and queries answer 1.
//   Sequencing: one request at a time. The single-port word memory takes
//   a read step and a check/write-back step per probe; a query also has
//   a done step, and a miss ends it early. req_stall is high while a
//   request is in progress. After reset the store is cleared one word per
//   cycle, FILTER_BITS/64 words (1024 by default), with req_stall high;
//   register writes work. The response sits in an output register: the
//   next request is taken while it waits under rsp_stall, and a later
//   query waits for it to go.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_top
   import bfdh_pkg::*;
#(
   parameter int FILTER_BITS = FILTER_BITS_DEF,
   parameter int MAX_PROBES  = MAX_PROBES_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [63:0]           req_hash_a,
   input  logic [63:0]           req_hash_b,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_maybe_present,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [NUM_PROBES_W-1:0] num_probes;
   dp_cmd_type              cmd;
   dp_sts_type              sts;

   bfdh_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .num_probes (num_probes)
   );

   bfdh_ctrl #(
      .MAX_PROBES (MAX_PROBES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_kind          (req_kind),
      .req_stall         (req_stall),
      .num_probes        (num_probes),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_maybe_present (rsp_maybe_present),
      .rsp_stall         (rsp_stall)
   );

   bfdh_dpath #(
      .FILTER_BITS (FILTER_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_hash_a (req_hash_a),
      .req_hash_b (req_hash_b),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

>>> tb/bloom_filter_double_hash_checker.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_checker
// Watches the request, response and register ports of the Bloom filter,
// keeps its own copy of the bit store and probe count, predicts the answer
// of every accepted query and compares it with the response that comes back.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_checker
   import bfdh_pkg::*;
#(
   parameter int FILTER_BITS = FILTER_BITS_DEF,
   parameter int MAX_PROBES  = MAX_PROBES_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_kind,
   input  logic [63:0]           req_hash_a,
   input  logic [63:0]           req_hash_b,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_maybe_present,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    pending,
   output int                    present_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILTER_WORDS = FILTER_BITS / WORD_W;

   // Shadow of the bit store and the probe count register
   logic [WORD_W-1:0]       filter_words [FILTER_WORDS];
   logic [NUM_PROBES_W-1:0] probe_cnt;
   // Expected maybe_present of each query still in flight
   logic                    presence_q [$];

   function automatic int unsigned probes_in_use();
      return (probe_cnt > MAX_PROBES) ? MAX_PROBES : probe_cnt;
   endfunction

   // Bit index of probe i: wraps at 2^64, then masked to the store size
   function automatic int unsigned probe_bit(logic [63:0] a, logic [63:0] b, int unsigned i);
      logic [63:0] pos;
      pos = a + 64'(i) * b;
      return int'(pos & 64'(FILTER_BITS - 1));
   endfunction

   function automatic logic all_probes_set(logic [63:0] a, logic [63:0] b);
      int unsigned idx;
      for (int unsigned i = 0; i < probes_in_use(); i++) begin
         idx = probe_bit(a, b, i);
         // bits run MSB first inside a word
         if (!filter_words[idx / WORD_W][WORD_W - 1 - idx % WORD_W])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic set_probe_bits(logic [63:0] a, logic [63:0] b);
      int unsigned idx;
      for (int unsigned i = 0; i < probes_in_use(); i++) begin
         idx = probe_bit(a, b, i);
         filter_words[idx / WORD_W][WORD_W - 1 - idx % WORD_W] = 1'b1;
      end
   endtask

   initial begin
      fail_count    = 0;
      pending       = 0;
      present_count = 0;
   end

   always @(posedge clock) begin
      logic expected;
      if (reset) begin
         foreach (filter_words[w]) filter_words[w] = '0;
         probe_cnt = NUM_PROBES_RST;
         presence_q.delete();
      end else begin
         // response against oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (presence_q.size() == 0) begin
               $display("%0t: response with no query outstanding, expected none, actual %0b",
                        $time, rsp_maybe_present);
               fail_count <= fail_count + 1;
            end else begin
               expected = presence_q.pop_front();
               if (rsp_maybe_present !== expected) begin
                  $display("%0t: maybe_present mismatch, expected %0b, actual %0b",
                           $time, expected, rsp_maybe_present);
                  fail_count <= fail_count + 1;
               end
               if (expected) present_count <= present_count + 1;
            end
         end

         // accepted request updates the shadow store or queues an answer
         if (req_valid && !req_stall) begin
            if (req_kind == KIND_INSERT)
               set_probe_bits(req_hash_a, req_hash_b);
            else
               presence_q.push_back(all_probes_set(req_hash_a, req_hash_b));
         end

         // register write lands on the access cycle, seen by later requests
         if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_PROBES)
            probe_cnt = pwdata[NUM_PROBES_W-1:0];
      end
      pending <= presence_q.size();
   end

endmodule

>>> tb/bloom_filter_double_hash_top_tb.sv
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_top_tb
// Drives inserts and queries into the Bloom filter under several probe
// counts, with random gaps on the request side and random stalls on the
// response side; a checker beside the block predicts and compares answers.
// ----------------------------------------------------------------------------
module bloom_filter_double_hash_top_tb
   import bfdh_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] ADDR_NUM_PROBES = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_NO_REG     = 3'd4;  // index 1, nothing there
   localparam int                    CYCLE_LIMIT     = 300000;
   localparam int                    SETTLE_CYCLES   = 40;    // outlasts the longest insert
   localparam int                    NUM_PHASES      = 10;
   localparam int                    PHASE_ITEMS     = 40;
   localparam int                    POOL_DEPTH      = 64;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
   } key_pair_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_INSERT;
   logic [63:0]           req_hash_a = '0;
   logic [63:0]           req_hash_b = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_maybe_present;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int           fail_count;
   int           pending;
   int           present_count;
   int           cycles = 0;
   logic         quiet = 1'b0;    // no gaps, no stalls
   int           inserts_sent = 0;
   int           queries_sent = 0;
   int           settings_used = 1;
   key_pair_type inserted_keys [$];

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   bloom_filter_double_hash_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_hash_a        (req_hash_a),
      .req_hash_b        (req_hash_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_maybe_present (rsp_maybe_present),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   bloom_filter_double_hash_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_hash_a        (req_hash_a),
      .req_hash_b        (req_hash_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_maybe_present (rsp_maybe_present),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .fail_count        (fail_count),
      .pending           (pending),
      .present_count     (present_count)
   );

   // Response side back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !quiet && ($urandom_range(99) < 33);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d queries unanswered", $time, pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [63:0] pick_hash();
      case ($urandom_range(9))
         0: return '1;
         1: return '0;
         2: return 64'($urandom_range(255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // One request, held until the block takes it
   task automatic send_request(logic kind, logic [63:0] a, logic [63:0] b);
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_hash_a <= a;
      req_hash_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_INSERT) inserts_sent++;
      else                     queries_sent++;
   endtask

   // Random sender gap
   task automatic maybe_idle();
      if (!quiet && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Hold off until every answer is back and the last insert has finished
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; pready is always high
   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      logic [NUM_PROBES_W-1:0] probes;
      logic                    kind;
      key_pair_type            key;
      int                      roll;
      int                      items;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: default two probes
      send_request(KIND_QUERY,  '0, '0);                 // empty store
      send_request(KIND_INSERT, '0, '0);
      send_request(KIND_QUERY,  '0, '0);
      send_request(KIND_QUERY,  '0, 64'd1);              // first probe hits, second misses
      send_request(KIND_INSERT, '1, '1);
      send_request(KIND_QUERY,  '1, '1);
      // second probe wraps around 2^64
      send_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFC0, 64'h0000_0000_0000_0080);
      send_request(KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFC0, 64'h0000_0000_0000_0080);
      send_request(KIND_QUERY,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_request(KIND_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      wait_for_results();

      // Zero probes: inserts do nothing, queries always answer present
      write_reg(ADDR_NUM_PROBES, 32'hFFFF_FFE0);
      send_request(KIND_QUERY,  {$urandom, $urandom}, {$urandom, $urandom});
      send_request(KIND_INSERT, 64'd4242, 64'd3);
      send_request(KIND_QUERY,  64'd4243, 64'd5);
      wait_for_results();

      // Write to a register index that does not exist: ignored
      write_reg(ADDR_NO_REG, 32'hFFFF_FFFF);
      send_request(KIND_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
      wait_for_results();

      // Probe count above the maximum is clamped
      write_reg(ADDR_NUM_PROBES, 32'h0000_001F);
      send_request(KIND_INSERT, 64'd123, 64'd7);
      send_request(KIND_QUERY,  64'd123, 64'd7);
      send_request(KIND_QUERY,  64'd123, 64'd14);
      wait_for_results();
      settings_used += 2;

      // Random phases: extremes first, then random probe counts
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: probes = 5'd1;
            1: probes = 5'd16;
            2: probes = 5'd31;
            3: probes = 5'd0;
            default: probes = ($urandom_range(3) == 0) ? NUM_PROBES_W'($urandom_range(17, 31))
                                                       : NUM_PROBES_W'($urandom_range(1, 16));
         endcase
         // upper bits random, only the low field counts
         write_reg(ADDR_NUM_PROBES, {27'($urandom), probes});
         if ($urandom_range(2) == 0)
            write_reg(ADDR_NO_REG, $urandom);
         settings_used++;
         quiet = (ph == 5);
         items = (probes == 0) ? 10 : PHASE_ITEMS;

         for (int n = 0; n < items; n++) begin
            maybe_idle();
            roll = $urandom_range(99);
            if (roll < 40) begin
               kind = KIND_INSERT;
               if ($urandom_range(3) == 0)
                  key = '{a: 64'($urandom_range(255)), b: 64'($urandom_range(7))};
               else
                  key = '{a: pick_hash(), b: pick_hash()};
               inserted_keys.push_back(key);
               if (inserted_keys.size() > POOL_DEPTH) void'(inserted_keys.pop_front());
            end else if (roll < 85 && inserted_keys.size() > 0) begin
               // mostly ask about keys that went in
               kind = KIND_QUERY;
               key  = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
            end else begin
               kind = KIND_QUERY;
               if ($urandom_range(1) == 0)
                  key = '{a: 64'($urandom_range(255)), b: 64'($urandom_range(7))};
               else
                  key = '{a: pick_hash(), b: pick_hash()};
            end
            send_request(kind, key.a, key.b);
            // occasional full drain mid-phase
            if ($urandom_range(99) < 2)
               wait_for_results();
         end
         wait_for_results();
      end
      quiet = 1'b0;

      $display("Run covered %0d inserts and %0d queries (%0d answered present)",
               inserts_sent, queries_sent, present_count);
      $display("over %0d probe-count settings, zero, one, sixteen and above the max among them",
               settings_used);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
